// File: hw/rtl/assert_macros.svh
// assertion helpers, sampled on the rising edge of clk_i, off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/rbce_pkg.sv
`timescale 1ns / 1ps
package rbce_pkg;

  localparam int KEY_BLOCKS_DEF = 8192;
  localparam int BLK_W          = 13;   // block number field, bits 23..11 of r2
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [23:0] TARGET_MASK   = 24'hfffffe;
  localparam logic [8:0]  SVC_ZERO_CODE = 9'h100;

  typedef enum logic [3:0] {
    OP_SPM  = 4'h4,
    OP_BALR = 4'h5,
    OP_BCTR = 4'h6,
    OP_BCR  = 4'h7,
    OP_SSK  = 4'h8,
    OP_ISK  = 4'h9,
    OP_SVC  = 4'ha,
    OP_MVCL = 4'he,
    OP_CLCL = 4'hf
  } op_e;

  typedef enum logic [1:0] {
    PCHK_NONE      = 2'd0,
    PCHK_OPERATION = 2'd1,
    PCHK_PRIVILEGE = 2'd2,
    PCHK_SPEC      = 2'd3
  } pchk_e;

  typedef enum logic [1:0] {
    KEY_NONE,
    KEY_SET,
    KEY_INSERT
  } key_op_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  operand_byte;
    logic [31:0] first_reg_value;
    logic [31:0] second_reg_value;
    logic [23:0] instr_address;
    logic [1:0]  cond_code;
    logic [3:0]  program_mask;
    logic [1:0]  length_code;
    logic        problem_state;
  } rr_item_t;

  typedef struct packed {
    logic [23:0] next_address;
    logic [1:0]  new_cond_code;
    logic [3:0]  new_program_mask;
    logic        reg_write;
    logic [3:0]  reg_number;
    logic [31:0] reg_value;
    logic [1:0]  program_check;
    logic        svc_request;
    logic [8:0]  svc_code;
  } rr_result_t;

  // classified item handed from the front to the back
  typedef struct packed {
    rr_result_t       res;
    key_op_e          key_op;
    logic [4:0]       key_data;
    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] blk_quot;
  } rbce_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// File: hw/rtl/rbce_front.sv
`timescale 1ns / 1ps
module rbce_front #(
  parameter int KEY_BLOCKS = rbce_pkg::KEY_BLOCKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  rbce_pkg::rr_item_t    item_i,
  output rbce_pkg::rbce_entry_t entry_o
);
  import rbce_pkg::*;

  // block number modulo KEY_BLOCKS: quotient by reciprocal here, remainder in the back
  localparam int KEY_IDX_W   = $clog2(KEY_BLOCKS);
  localparam int RECIP_SHIFT = BLK_W + KEY_IDX_W;
  localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + KEY_BLOCKS - 1) / KEY_BLOCKS;
  localparam int MUL_W       = BLK_W + 2;
  localparam int PROD_W      = BLK_W + MUL_W;

  logic              fetch_prot_q;
  logic [23:0]       seq_addr;
  logic [23:0]       target;
  logic [3:0]        r1;
  logic [3:0]        r2;
  logic [31:0]       dec_val;
  logic [BLK_W-1:0]  blk;
  logic [PROD_W-1:0] quot_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_prot_q <= 1'b1;
    end else if (cfg_we_i) begin
      fetch_prot_q <= cfg_wdata_i;
    end
  end

  assign seq_addr  = item_i.instr_address + 24'd2;
  assign target    = item_i.second_reg_value[23:0] & TARGET_MASK;
  assign r1        = item_i.operand_byte[7:4];
  assign r2        = item_i.operand_byte[3:0];
  assign dec_val   = item_i.first_reg_value - 32'd1;
  assign blk       = item_i.second_reg_value[23:11];
  assign quot_prod = PROD_W'(blk) * PROD_W'(RECIP_MUL);

  always_comb begin
    entry_o                      = '0;
    entry_o.key_op               = KEY_NONE;
    entry_o.blk                  = blk;
    entry_o.blk_quot             = BLK_W'(quot_prod >> RECIP_SHIFT);
    entry_o.key_data             = {item_i.first_reg_value[7:4],
                                    item_i.first_reg_value[3] & fetch_prot_q};
    entry_o.res.next_address     = seq_addr;
    entry_o.res.new_cond_code    = item_i.cond_code;
    entry_o.res.new_program_mask = item_i.program_mask;
    entry_o.res.program_check    = PCHK_NONE;
    case (op_e'(item_i.opcode))
      OP_SPM: begin
        entry_o.res.new_cond_code    = item_i.first_reg_value[29:28];
        entry_o.res.new_program_mask = item_i.first_reg_value[27:24];
      end
      OP_BALR: begin
        entry_o.res.reg_write  = 1'b1;
        entry_o.res.reg_number = r1;
        entry_o.res.reg_value  = {item_i.length_code, item_i.cond_code,
                                  item_i.program_mask, seq_addr};
        if (r2 != 4'd0) begin
          entry_o.res.next_address = target;
        end
      end
      OP_BCTR: begin
        entry_o.res.reg_write  = 1'b1;
        entry_o.res.reg_number = r1;
        entry_o.res.reg_value  = dec_val;
        if (dec_val != 32'd0 && r2 != 4'd0) begin
          entry_o.res.next_address = target;
        end
      end
      OP_BCR: begin
        if (item_i.operand_byte[{1'b1, ~item_i.cond_code}] && r2 != 4'd0) begin
          entry_o.res.next_address = target;
        end
      end
      OP_SSK, OP_ISK: begin
        if (item_i.problem_state) begin
          entry_o.res.program_check = PCHK_PRIVILEGE;
        end else if (item_i.second_reg_value[3:0] != 4'd0) begin
          entry_o.res.program_check = PCHK_SPEC;
        end else if (op_e'(item_i.opcode) == OP_SSK) begin
          entry_o.key_op = KEY_SET;
        end else begin
          entry_o.key_op         = KEY_INSERT;
          entry_o.res.reg_write  = 1'b1;
          entry_o.res.reg_number = r1;
          entry_o.res.reg_value  = item_i.first_reg_value;
        end
      end
      OP_SVC: begin
        entry_o.res.svc_request = 1'b1;
        entry_o.res.svc_code    = (item_i.operand_byte == 8'd0) ? SVC_ZERO_CODE
                                                                : {1'b0, item_i.operand_byte};
      end
      OP_MVCL, OP_CLCL: begin
        entry_o.res.next_address = seq_addr;
      end
      default: begin
        entry_o.res.program_check = PCHK_OPERATION;
      end
    endcase
  end

endmodule

// File: hw/rtl/rbce_queue.sv
`timescale 1ns / 1ps
module rbce_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rbce_pkg::rbce_entry_t push_data_i,
  input  logic                  pop_i,
  output rbce_pkg::rbce_entry_t pop_data_o,
  output rbce_pkg::q_status_t   status_o
);
  import rbce_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rbce_entry_t      slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.valid = (cnt_q != '0);
  assign pop_data_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/rbce_back.sv
`timescale 1ns / 1ps
module rbce_back #(
  parameter int KEY_BLOCKS = rbce_pkg::KEY_BLOCKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rbce_pkg::rbce_entry_t entry_i,
  input  logic                  entry_valid_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rbce_pkg::rr_result_t  out_data_o
);
  import rbce_pkg::*;

  localparam int KEY_IDX_W = $clog2(KEY_BLOCKS);
  localparam int REM_W     = 2 * BLK_W;

  logic [4:0]           key_mem [KEY_BLOCKS];
  logic [KEY_IDX_W-1:0] clr_idx_q;
  logic                 clr_done_q;
  logic [REM_W-1:0]     rem_prod;
  logic [BLK_W-1:0]     blk_rem;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [KEY_IDX_W-1:0] wr_addr;
  logic                 mem_we;
  logic [4:0]           mem_wdata;
  logic [4:0]           rd_key_q;
  rbce_entry_t          s1_q;
  logic                 s1_valid_q;
  logic                 s1_adv;
  rr_result_t           result;
  rr_result_t           out_q;
  logic                 out_valid_q;

  // remainder of the block number, quotient came from the front
  assign rem_prod = REM_W'(entry_i.blk_quot) * REM_W'(KEY_BLOCKS);
  assign blk_rem  = entry_i.blk - BLK_W'(rem_prod);
  assign key_idx  = blk_rem[KEY_IDX_W-1:0];

  assign clearing_o = !clr_done_q;
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o      = entry_valid_i && clr_done_q && (!s1_valid_q || s1_adv);

  assign mem_we    = !clr_done_q || (pop_o && entry_i.key_op == KEY_SET);
  assign wr_addr   = clr_done_q ? key_idx : clr_idx_q;
  assign mem_wdata = clr_done_q ? entry_i.key_data : 5'd0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[wr_addr] <= mem_wdata;
    end
    if (pop_o) begin
      rd_key_q <= key_mem[key_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      if (clr_idx_q == KEY_IDX_W'(KEY_BLOCKS - 1)) begin
        clr_done_q <= 1'b1;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  always_comb begin
    result = s1_q.res;
    if (s1_q.key_op == KEY_INSERT) begin
      result.reg_value = s1_q.res.reg_value | {24'd0, rd_key_q, 3'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= entry_i;
    end
    if (s1_adv) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/rr_branch_control_execute.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   in_data_i   (rr_item_t)
// out       output     out_valid_o / out_stall_i out_data_o  (rr_result_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (fetch protection on)
//
// one item per cycle sustained while out_stall_i stays low; a taken item passes the queue,
// the key store read and the output register before its result is valid
// after reset the key store is swept to zero, one block a cycle, all KEY_BLOCKS blocks
// (8192 at the default) with in_stall_o high; cfg writes are taken throughout
// a 2-entry queue sits between decode and execute, so input keeps flowing while
// a finished result waits on out_stall_i until the queue fills
`include "assert_macros.svh"
module rr_branch_control_execute #(
  parameter int KEY_BLOCKS = rbce_pkg::KEY_BLOCKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rbce_pkg::rr_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rbce_pkg::rr_result_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i
);
  import rbce_pkg::*;

  rbce_entry_t front_entry;
  rbce_entry_t queue_head;
  q_status_t   q_status;
  logic        push;
  logic        pop;
  logic        clearing;

  // front: decode the opcode, work out branches, link words and checks
  rbce_front #(
    .KEY_BLOCKS(KEY_BLOCKS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (in_data_i),
    .entry_o    (front_entry)
  );

  // take an item whenever the queue has room and the key sweep is over
  assign in_stall_o = q_status.full || clearing;
  assign push       = in_valid_i && !in_stall_o;

  rbce_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_entry),
    .pop_i      (pop),
    .pop_data_o (queue_head),
    .status_o   (q_status)
  );

  // back: key store access for SSK / ISK and the output register
  rbce_back #(
    .KEY_BLOCKS(KEY_BLOCKS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (queue_head),
    .entry_valid_i(q_status.valid),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // no item may enter while the key store is still being swept
  `ASSERT_IMPL(a_no_take_in_sweep, clearing, in_stall_o && !pop)
  // no write-back means no register number or value
  `ASSERT_IMPL(a_wb_fields_clean, out_valid_o && !out_data_o.reg_write,
               out_data_o.reg_number == 4'd0 && out_data_o.reg_value == 32'd0)
  // a supervisor call carries no program check and no write-back
  `ASSERT_IMPL(a_svc_alone, out_valid_o && out_data_o.svc_request,
               out_data_o.program_check == PCHK_NONE && !out_data_o.reg_write)
  // the queue never pops empty
  `ASSERT_IMPL(a_pop_has_item, pop, q_status.valid)

endmodule

// File: tb/rbce_score_pkg.sv
`timescale 1ns / 1ps
package rbce_score_pkg;

  import rbce_pkg::*;

  class rr_result_board;
    rr_result_t  due_results[$];
    logic [4:0]  key_mem [KEY_BLOCKS_DEF];
    bit          fetch_protect;
    int unsigned failures;

    function new();
      foreach (key_mem[i]) key_mem[i] = 5'd0;
      fetch_protect = 1'b1;
      failures      = 0;
    endfunction

    // executes one rr instruction against the local key store
    function rr_result_t execute_rr(rr_item_t it);
      rr_result_t r;
      logic [3:0] r1;
      logic [3:0] r2;
      logic [4:0] key;
      int         blk;
      r1 = it.operand_byte[7:4];
      r2 = it.operand_byte[3:0];
      r = '0;
      r.next_address     = it.instr_address + 24'd2;
      r.new_cond_code    = it.cond_code;
      r.new_program_mask = it.program_mask;
      case (it.opcode)
        OP_SPM: begin
          r.new_cond_code    = it.first_reg_value[29:28];
          r.new_program_mask = it.first_reg_value[27:24];
        end
        OP_BALR: begin
          r.reg_write  = 1'b1;
          r.reg_number = r1;
          r.reg_value  = {it.length_code, it.cond_code, it.program_mask, r.next_address};
          if (r2 != 4'd0) r.next_address = it.second_reg_value[23:0] & TARGET_MASK;
        end
        OP_BCTR: begin
          r.reg_write  = 1'b1;
          r.reg_number = r1;
          r.reg_value  = it.first_reg_value - 32'd1;
          if (r.reg_value != 32'd0 && r2 != 4'd0)
            r.next_address = it.second_reg_value[23:0] & TARGET_MASK;
        end
        OP_BCR: begin
          if (((8'h80 >> it.cond_code) & it.operand_byte) != 8'd0 && r2 != 4'd0)
            r.next_address = it.second_reg_value[23:0] & TARGET_MASK;
        end
        OP_SSK, OP_ISK: begin
          if (it.problem_state) begin
            r.program_check = PCHK_PRIVILEGE;
          end else if (it.second_reg_value[3:0] != 4'd0) begin
            r.program_check = PCHK_SPEC;
          end else begin
            blk = int'(it.second_reg_value[23:11]) % KEY_BLOCKS_DEF;
            if (it.opcode == OP_SSK) begin
              key = it.first_reg_value[7:3];
              if (!fetch_protect) key[0] = 1'b0;
              key_mem[blk] = key;
            end else begin
              r.reg_write  = 1'b1;
              r.reg_number = r1;
              r.reg_value  = it.first_reg_value | {24'd0, key_mem[blk], 3'd0};
            end
          end
        end
        OP_SVC: begin
          r.svc_request = 1'b1;
          r.svc_code    = (it.operand_byte == 8'd0) ? SVC_ZERO_CODE : {1'b0, it.operand_byte};
        end
        OP_MVCL, OP_CLCL: ;
        default: r.program_check = PCHK_OPERATION;
      endcase
      return r;
    endfunction

    function void note_item(rr_item_t it);
      due_results.push_back(execute_rr(it));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(rr_result_t got);
      rr_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing due, got %0h", $time, got);
        failures++;
        return;
      end
      want = due_results.pop_front();
      check_field("next_address", want.next_address, got.next_address);
      check_field("new_cond_code", want.new_cond_code, got.new_cond_code);
      check_field("new_program_mask", want.new_program_mask, got.new_program_mask);
      check_field("reg_write", want.reg_write, got.reg_write);
      check_field("reg_number", want.reg_number, got.reg_number);
      check_field("reg_value", want.reg_value, got.reg_value);
      check_field("program_check", want.program_check, got.program_check);
      check_field("svc_request", want.svc_request, got.svc_request);
      check_field("svc_code", want.svc_code, got.svc_code);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

endpackage

// File: tb/rr_branch_control_execute_test.sv
`timescale 1ns / 1ps
module rr_branch_control_execute_test;

  import rbce_pkg::*;
  import rbce_score_pkg::*;

  // every block input starts at a known value
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  rr_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  rr_result_t out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;

  // when set, neither side idles
  bit steady = 1'b0;

  rr_result_board board;

  rr_branch_control_execute DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 14);
  end

  // results are taken at the rising edge where valid is high and stall is low
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  function automatic rr_item_t pack_rr(logic [3:0] op, logic [7:0] ob, logic [31:0] r1v,
                                       logic [31:0] r2v, logic [23:0] ia, logic [1:0] cc,
                                       logic [3:0] pm, logic [1:0] ilc, logic prob);
    rr_item_t it;
    it.opcode           = op;
    it.operand_byte     = ob;
    it.first_reg_value  = r1v;
    it.second_reg_value = r2v;
    it.instr_address    = ia;
    it.cond_code        = cc;
    it.program_mask     = pm;
    it.length_code      = ilc;
    it.problem_state    = prob;
    return it;
  endfunction

  // mostly well-formed key and branch instructions, the rest fully random
  function automatic rr_item_t random_item();
    rr_item_t    it;
    int unsigned pick;
    it.opcode           = 4'($urandom);
    it.operand_byte     = 8'($urandom);
    it.first_reg_value  = $urandom;
    it.second_reg_value = $urandom;
    it.instr_address    = 24'($urandom);
    it.cond_code        = 2'($urandom);
    it.program_mask     = 4'($urandom);
    it.length_code      = 2'($urandom);
    it.problem_state    = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.opcode = ($urandom_range(0, 1) != 0) ? OP_SSK : OP_ISK;
      // mostly supervisor state and a legal r2 so the key store is reached
      if ($urandom_range(0, 9) != 0) it.problem_state = 1'b0;
      if ($urandom_range(0, 9) != 0) it.second_reg_value[3:0] = 4'd0;
      // a few hot blocks at both ends so set and insert hit the same key
      if ($urandom_range(0, 3) != 0)
        it.second_reg_value[23:11] = ($urandom_range(0, 1) != 0) ?
                                     13'($urandom_range(0, 3)) :
                                     13'h1ffc + 13'($urandom_range(0, 3));
    end else if (pick < 75) begin
      it.opcode = 4'($urandom_range(int'(OP_BALR), int'(OP_BCR)));
      // r2 of zero never branches
      if ($urandom_range(0, 4) == 0) it.operand_byte[3:0] = 4'd0;
      // count that reaches zero
      if ($urandom_range(0, 4) == 0) it.first_reg_value = 32'd1;
    end
    // svc code zero now and then
    if ($urandom_range(0, 19) == 0) it.operand_byte = 8'd0;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  // valid stays high into the next call, so back-to-back items need no toggle
  task automatic send_item(input rr_item_t it);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(it);
    @(negedge clk_i);
  endtask

  // sender holds off until every due result is back, then lets the clock run on with valid low
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // only called with the block idle
  task automatic set_fetch_protect(input bit on);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.fetch_protect = on;
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      // pause in mid phase until the pipe is empty
      if (i == count / 2) drain();
      send_item(random_item());
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // every opcode once, address at the top so next address wraps to zero
    for (int op = 0; op < 16; op++)
      send_item(pack_rr(4'(op), 8'h5a, 32'h8765_4321, 32'hfedc_ba90, 24'hfffffe,
                        2'd3, 4'hf, 2'd3, 1'b0));
    // spm with all ones and with zero
    send_item(pack_rr(OP_SPM, 8'h10, 32'hffff_ffff, 32'h0, 24'h0, 2'd0, 4'h0, 2'd0, 1'b0));
    send_item(pack_rr(OP_SPM, 8'h10, 32'h0, 32'h0, 24'h0, 2'd3, 4'hf, 2'd0, 1'b0));
    // balr without branch, link word wraps; balr with branch to the top
    send_item(pack_rr(OP_BALR, 8'hf0, 32'h0, 32'hffff_ffff, 24'hffffff,
                      2'd3, 4'hf, 2'd3, 1'b1));
    send_item(pack_rr(OP_BALR, 8'h0f, 32'hffff_ffff, 32'hffff_ffff, 24'h0,
                      2'd0, 4'h0, 2'd0, 1'b0));
    // bctr reaching zero, and wrapping below zero
    send_item(pack_rr(OP_BCTR, 8'h21, 32'd1, 32'h0012_3457, 24'h000100,
                      2'd0, 4'h0, 2'd0, 1'b0));
    send_item(pack_rr(OP_BCTR, 8'h21, 32'd0, 32'h0012_3457, 24'h000100,
                      2'd0, 4'h0, 2'd0, 1'b0));
    // bcr taken on cc 3, not taken when the mask misses cc 1
    send_item(pack_rr(OP_BCR, 8'h1f, 32'h0, 32'h00ab_cdef, 24'h000200,
                      2'd3, 4'h0, 2'd0, 1'b0));
    send_item(pack_rr(OP_BCR, 8'h8f, 32'h0, 32'h00ab_cdef, 24'h000200,
                      2'd1, 4'h0, 2'd0, 1'b0));
    // key ops: problem state, bad r2 low bits, set then insert, top block
    send_item(pack_rr(OP_SSK, 8'h12, 32'hff, 32'h0000_2800, 24'h0, 2'd0, 4'h0, 2'd0, 1'b1));
    send_item(pack_rr(OP_ISK, 8'h12, 32'h0, 32'h0000_0801, 24'h0, 2'd0, 4'h0, 2'd0, 1'b0));
    send_item(pack_rr(OP_SSK, 8'h12, 32'hff, 32'h0000_2800, 24'h0, 2'd0, 4'h0, 2'd0, 1'b0));
    send_item(pack_rr(OP_ISK, 8'h32, 32'h0, 32'h0000_2800, 24'h0, 2'd0, 4'h0, 2'd0, 1'b0));
    send_item(pack_rr(OP_ISK, 8'hf2, 32'hffff_ffff, 32'hffff_f800, 24'h0,
                      2'd0, 4'h0, 2'd0, 1'b0));
    // svc with code zero
    send_item(pack_rr(OP_SVC, 8'h00, 32'h0, 32'h0, 24'h0, 2'd0, 4'h0, 2'd0, 1'b0));

    // fetch bit dropped, random idling on both sides
    drain();
    set_fetch_protect(1'b0);
    random_phase(200);

    // fetch bit kept, a long stretch with no idling at all
    drain();
    set_fetch_protect(1'b1);
    steady = 1'b1;
    random_phase(170);
    steady = 1'b0;

    drain();
    set_fetch_protect(1'b0);
    random_phase(180);

    drain();
    repeat (8) @(negedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("rr_branch_control_execute_test: clean");
    end else begin
      $display("rr_branch_control_execute_test: errors");
    end
    $finish;
  end

  // covers the key store sweep after reset with a wide margin
  initial begin
    #5_000_000;
    $display("rr_branch_control_execute_test: errors");
    $finish;
  end

endmodule
